// ===== rtl/ordered_list_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// shared forms for the concurrent checks of the list engine
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_ENGINE_TOP_MACROS_SVH

// condition holds at every clock edge outside reset
`define OLE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define OLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered list engine package
// field widths, function codes and status codes of the list engine
// ----------------------------------------------------------------------------
package ole_pkg;

   // default pool geometry
   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   // request and response field widths
   localparam int FUNC_W     = 3;
   localparam int IDX_W      = 5;
   localparam int ITEM_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - (ITEM_W + STATUS_W + LEN_W);

   // request function codes
   typedef enum logic [FUNC_W-1:0] {
      F_PREPEND      = 3'd0,
      F_APPEND       = 3'd1,
      F_INSERT       = 3'd2,
      F_READ         = 3'd3,
      F_REMOVE       = 3'd4,
      F_REMOVE_VALUE = 3'd5
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

// ===== rtl/ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
`include "ordered_list_engine_top_macros.svh"
// ----------------------------------------------------------------------------
// ordered list engine
// doubly linked list of signed values kept in a fixed node pool
// ----------------------------------------------------------------------------
// Each request item (prepend, append, insert at index, read at index, remove
// at index, remove first equal value) returns one response item with a value,
// a status and the new length. Node values and links live in two
// single-port-write memories with a registered read port; the walk from the
// head follows one link per cycle. One item is worked at a time: a read or
// remove walks from the head to its node, and a remove then repairs the
// links of its neighbors and writes back the freed node; an insert takes a
// free node and repairs its neighbors' links, and an insert in the middle
// first walks to the position before it. Freed nodes are chained through
// their next links, so no clearing pass is needed after reset. The next
// request item is taken while a finished response item still waits in the
// output register.

module ordered_list_engine_top
   import ole_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // func[2:0], index[7:3], item_value[39:8]
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // read_value[31:0], status[33:32],
                                             // list_length[38:34], zero[39]
);

   localparam int SW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
   localparam int LW   = 2 * SW;

   // sequencer states
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_WALK   = 10'b0000000010,
      S_POP_RD = 10'b0000000100,
      S_POP_WB = 10'b0000001000,
      S_PA_RD  = 10'b0000010000,
      S_PA_WR  = 10'b0000100000,
      S_PB_RD  = 10'b0001000000,
      S_PB_WR  = 10'b0010000000,
      S_FIN    = 10'b0100000000,
      S_RESP   = 10'b1000000000
   } state_type;

   // node memories
   logic [LW-1:0]          link_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
   logic [LW-1:0]          link_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;

   // memory ports
   logic [SW-1:0]          rd_addr;
   logic                   link_wr_en;
   logic [SW-1:0]          link_wr_addr;
   logic [LW-1:0]          link_wr_data;
   logic                   val_wr_en;

   // control state
   state_type              state_ff, state_in;
   logic [SW-1:0]          head_ff, head_in;
   logic [SW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          fresh_ff, fresh_in;
   logic [SW-1:0]          free_head_ff, free_head_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // per item working registers
   func_type               func_ff, func_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                   ins_ff, ins_in;
   logic                   by_val_ff, by_val_in;
   logic [CW-1:0]          target_ff, target_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [SW-1:0]          cur_ff, cur_in;
   logic [SW-1:0]          n_ff, n_in;
   logic                   pop_ff, pop_in;
   logic                   pa_en_ff, pa_en_in;
   logic [SW-1:0]          pa_slot_ff, pa_slot_in;
   logic [SW-1:0]          pa_data_ff, pa_data_in;
   logic                   pb_en_ff, pb_en_in;
   logic [SW-1:0]          pb_slot_ff, pb_slot_in;
   logic [SW-1:0]          pb_data_ff, pb_data_in;
   logic [SW-1:0]          dw_slot_ff, dw_slot_in;
   logic [SW-1:0]          dw_next_ff, dw_next_in;
   logic [SW-1:0]          dw_prev_ff, dw_prev_in;
   logic [VALUE_WIDTH-1:0] res_val_ff, res_val_in;
   status_type             res_status_ff, res_status_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // request fields and helpers
   func_type                   req_func;
   logic [IDX_W-1:0]           req_index;
   logic signed [ITEM_W-1:0]   req_item;
   logic [CMPW-1:0]            idx_x;
   logic [CMPW-1:0]            cnt_x;
   logic [CMPW-1:0]            pos_x;
   logic                       reuse;
   logic [SW-1:0]              alloc_slot;
   logic [SW-1:0]              rd_next;
   logic [SW-1:0]              rd_prev;
   logic                       found;
   logic                       first;
   logic                       last;
   logic signed [VALUE_WIDTH-1:0] res_val_s;

   // first state of a planned set of memory updates
   function automatic state_type after_plan(input logic pop, input logic pa,
                                            input logic pb);
      state_type nxt;
      if (pop) begin
         nxt = S_POP_RD;
      end else if (pa) begin
         nxt = S_PA_RD;
      end else if (pb) begin
         nxt = S_PB_RD;
      end else begin
         nxt = S_FIN;
      end
      return nxt;
   endfunction

   // request unpacking
   assign req_func  = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_index = req_tdata[FUNC_W +: IDX_W];
   assign req_item  = req_tdata[FUNC_W + IDX_W +: ITEM_W];
   assign idx_x     = CMPW'(req_index);
   assign cnt_x     = CMPW'(count_ff);

   // list position an insert goes to
   always_comb begin
      case (req_func)
         F_PREPEND: pos_x = '0;
         F_APPEND:  pos_x = cnt_x;
         default:   pos_x = idx_x;
      endcase
   end

   // allocation: freed nodes first, then never-used ones
   assign reuse      = (fresh_ff != count_ff);
   assign alloc_slot = reuse ? free_head_ff : fresh_ff[SW-1:0];

   // fields of the node just read
   assign rd_next = link_rd_ff[LW-1:SW];
   assign rd_prev = link_rd_ff[SW-1:0];
   assign found   = by_val_ff ? (val_rd_ff == key_ff) : (pos_ff == target_ff);
   assign first   = (pos_ff == '0);
   assign last    = (pos_ff + CW'(1) == count_ff);

   assign res_val_s = res_val_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      free_head_in  = free_head_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      ins_in        = ins_ff;
      by_val_in     = by_val_ff;
      target_in     = target_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      pop_in        = pop_ff;
      pa_en_in      = pa_en_ff;
      pa_slot_in    = pa_slot_ff;
      pa_data_in    = pa_data_ff;
      pb_en_in      = pb_en_ff;
      pb_slot_in    = pb_slot_ff;
      pb_data_in    = pb_data_ff;
      dw_slot_in    = dw_slot_ff;
      dw_next_in    = dw_next_ff;
      dw_prev_in    = dw_prev_ff;
      res_val_in    = res_val_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rd_addr       = head_ff;
      link_wr_en    = 1'b0;
      link_wr_addr  = dw_slot_ff;
      link_wr_data  = {dw_next_ff, dw_prev_ff};
      val_wr_en     = 1'b0;

      case (state_ff)
         // accept an item, check it and plan the work
         S_IDLE: begin
            rd_addr = head_ff;
            if (req_tvalid) begin
               func_in       = req_func;
               key_in        = VALUE_WIDTH'(req_item);
               ins_in        = 1'b0;
               by_val_in     = 1'b0;
               pop_in        = 1'b0;
               pa_en_in      = 1'b0;
               pb_en_in      = 1'b0;
               pos_in        = '0;
               cur_in        = head_ff;
               res_val_in    = '0;
               res_status_in = ST_OK;
               case (req_func)
                  F_PREPEND, F_APPEND, F_INSERT: begin
                     ins_in = 1'b1;
                     if (pos_x > cnt_x) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESP;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        n_in       = alloc_slot;
                        pop_in     = reuse;
                        dw_slot_in = alloc_slot;
                        if (!reuse) begin
                           fresh_in = fresh_ff + CW'(1);
                        end
                        if (count_ff == '0) begin
                           // first node of an empty list
                           head_in    = alloc_slot;
                           tail_in    = alloc_slot;
                           dw_next_in = '0;
                           dw_prev_in = '0;
                           state_in   = after_plan(reuse, 1'b0, 1'b0);
                        end else if (pos_x == '0) begin
                           // new head
                           pb_en_in   = 1'b1;
                           pb_slot_in = head_ff;
                           pb_data_in = alloc_slot;
                           dw_next_in = head_ff;
                           dw_prev_in = '0;
                           head_in    = alloc_slot;
                           state_in   = after_plan(reuse, 1'b0, 1'b1);
                        end else if (pos_x == cnt_x) begin
                           // new tail
                           pa_en_in   = 1'b1;
                           pa_slot_in = tail_ff;
                           pa_data_in = alloc_slot;
                           dw_next_in = '0;
                           dw_prev_in = tail_ff;
                           tail_in    = alloc_slot;
                           state_in   = after_plan(reuse, 1'b1, 1'b0);
                        end else begin
                           // walk to the node before the position
                           target_in = pos_x[CW-1:0] - CW'(1);
                           state_in  = S_WALK;
                        end
                     end
                  end
                  F_READ, F_REMOVE: begin
                     if (idx_x < cnt_x) begin
                        target_in = idx_x[CW-1:0];
                        state_in  = S_WALK;
                     end else begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESP;
                     end
                  end
                  F_REMOVE_VALUE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESP;
                     end else begin
                        by_val_in = 1'b1;
                        state_in  = S_WALK;
                     end
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         // one node per cycle from the head
         S_WALK: begin
            rd_addr = rd_next;
            if (found) begin
               if (ins_ff) begin
                  // link the new node between cur and its successor
                  pa_en_in   = 1'b1;
                  pa_slot_in = cur_ff;
                  pa_data_in = n_ff;
                  pb_en_in   = 1'b1;
                  pb_slot_in = rd_next;
                  pb_data_in = n_ff;
                  dw_next_in = rd_next;
                  dw_prev_in = cur_ff;
                  state_in   = after_plan(pop_ff, 1'b1, 1'b1);
               end else if (func_ff == F_READ) begin
                  res_val_in = val_rd_ff;
                  state_in   = S_RESP;
               end else begin
                  // unlink cur and push it on the free chain
                  res_val_in   = val_rd_ff;
                  pop_in       = 1'b0;
                  pa_en_in     = !first;
                  pa_slot_in   = rd_prev;
                  pa_data_in   = last ? '0 : rd_next;
                  pb_en_in     = !last;
                  pb_slot_in   = rd_next;
                  pb_data_in   = first ? '0 : rd_prev;
                  if (first) begin
                     head_in = last ? '0 : rd_next;
                  end
                  if (last) begin
                     tail_in = first ? '0 : rd_prev;
                  end
                  dw_slot_in   = cur_ff;
                  dw_next_in   = free_head_ff;
                  dw_prev_in   = '0;
                  free_head_in = cur_ff;
                  state_in     = after_plan(1'b0, !first, !last);
               end
            end else if (by_val_ff && last) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               cur_in = rd_next;
               pos_in = pos_ff + CW'(1);
            end
         end

         // take the new node off the free chain
         S_POP_RD: begin
            rd_addr  = n_ff;
            state_in = S_POP_WB;
         end
         S_POP_WB: begin
            free_head_in = rd_next;
            state_in     = after_plan(1'b0, pa_en_ff, pb_en_ff);
         end

         // predecessor next link repair
         S_PA_RD: begin
            rd_addr  = pa_slot_ff;
            state_in = S_PA_WR;
         end
         S_PA_WR: begin
            link_wr_en   = 1'b1;
            link_wr_addr = pa_slot_ff;
            link_wr_data = {pa_data_ff, rd_prev};
            state_in     = after_plan(1'b0, 1'b0, pb_en_ff);
         end

         // successor prev link repair
         S_PB_RD: begin
            rd_addr  = pb_slot_ff;
            state_in = S_PB_WR;
         end
         S_PB_WR: begin
            link_wr_en   = 1'b1;
            link_wr_addr = pb_slot_ff;
            link_wr_data = {rd_next, pb_data_ff};
            state_in     = S_FIN;
         end

         // write back the node itself and the count
         S_FIN: begin
            link_wr_en   = 1'b1;
            link_wr_addr = dw_slot_ff;
            link_wr_data = {dw_next_ff, dw_prev_ff};
            val_wr_en    = ins_ff;
            count_in     = ins_ff ? count_ff + CW'(1) : count_ff - CW'(1);
            state_in     = S_RESP;
         end

         // hand the item to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, cnt_x[LEN_W-1:0],
                               res_status_ff,
                               (res_status_ff == ST_OK) ? ITEM_W'(res_val_s)
                                                        : {ITEM_W{1'b0}}};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // node memories: write port and registered read port
   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (val_wr_en) begin
         val_mem[dw_slot_ff] <= key_ff;
      end
      link_rd_ff <= link_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      ins_ff        <= ins_in;
      by_val_ff     <= by_val_in;
      target_ff     <= target_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      n_ff          <= n_in;
      pop_ff        <= pop_in;
      pa_en_ff      <= pa_en_in;
      pa_slot_ff    <= pa_slot_in;
      pa_data_ff    <= pa_data_in;
      pb_en_ff      <= pb_en_in;
      pb_slot_ff    <= pb_slot_in;
      pb_data_ff    <= pb_data_in;
      dw_slot_ff    <= dw_slot_in;
      dw_next_ff    <= dw_next_in;
      dw_prev_ff    <= dw_prev_in;
      res_val_ff    <= res_val_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `OLE_ASSERT_ALWAYS(a_pool_count, clock, reset, fresh_ff >= count_ff && count_ff <= CW'(CAPACITY), "free chain count out of range")
   `OLE_ASSERT_SAME(a_walk_bound, clock, reset, state_ff == S_WALK, pos_ff < count_ff, "walk ran past the tail")
   `OLE_ASSERT_NEXT(a_resp_hold, clock, reset, state_ff == S_RESP && rsp_valid_ff && !rsp_tready, state_ff == S_RESP, "response overwrote a pending item")

endmodule
